// ===== rtl/core/wpp_pkg.sv =====
// package for the window peak-to-peak maximum block
// holds the default sizes, fixed field widths and the stage control struct
// no dependencies

package wpp_pkg;

  // default sizes for the top level parameters
  localparam int unsigned MAX_WINDOW_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  // fixed widths of the window length register and the result field
  localparam int unsigned LEN_W = 7;
  localparam int unsigned OUT_W = 32;

  // control that travels with an item from stage to stage
  typedef struct packed {
    logic valid;  // an item sits in this stage
    logic last;   // the item closes its data set
    logic full;   // a full window ends at this item
  } wpp_ctrl_t;

endpackage

// ===== rtl/core/wpp_cell.sv =====
// one cell of the running max/min chain
// cell k keeps the max and min of the last k+1 samples; uses wpp_pkg

module wpp_cell #(
  parameter int unsigned SampleWidth = wpp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [SampleWidth-1:0] sample_i,
  input  logic [SampleWidth-1:0] prev_max_i,
  input  logic [SampleWidth-1:0] prev_min_i,
  output logic [SampleWidth-1:0] max_o,
  output logic [SampleWidth-1:0] min_o
);
  import wpp_pkg::*;

  logic [SampleWidth-1:0] max_d, max_q;
  logic [SampleWidth-1:0] min_d, min_q;

  // fold the new sample into the neighbor's shorter window
  always_comb begin
    max_d = (sample_i > prev_max_i) ? sample_i : prev_max_i;
    min_d = (sample_i < prev_min_i) ? sample_i : prev_min_i;
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  assign max_o = max_q;
  assign min_o = min_q;

endmodule

// ===== rtl/core/wpp_select.sv =====
// window tap select and spread stage
// picks the cell whose span equals the window length, registers max - min; uses wpp_pkg

module wpp_select #(
  parameter int unsigned MaxWindow   = wpp_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SampleWidth = wpp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         stall_i,
  input  logic [wpp_pkg::LEN_W-1:0]    len_i,
  input  wpp_pkg::wpp_ctrl_t           ctrl_i,
  input  logic [SampleWidth-1:0]       max_i [MaxWindow],
  input  logic [SampleWidth-1:0]       min_i [MaxWindow],
  output wpp_pkg::wpp_ctrl_t           ctrl_o,
  output logic [SampleWidth-1:0]       spread_o
);
  import wpp_pkg::*;

  logic [MaxWindow-1:0]   sel;
  logic [SampleWidth-1:0] hi;
  logic [SampleWidth-1:0] lo;
  wpp_ctrl_t              ctrl_q;
  logic [SampleWidth-1:0] spread_q;

  // one-hot tap: cell k spans k+1 samples
  always_comb begin
    for (int k = 0; k < MaxWindow; k++) begin
      sel[k] = (32'(len_i) == 32'(k + 1));
    end
  end

  // and-or mux over the cells
  always_comb begin
    hi = '0;
    lo = '0;
    for (int k = 0; k < MaxWindow; k++) begin
      hi = hi | (max_i[k] & {SampleWidth{sel[k]}});
      lo = lo | (min_i[k] & {SampleWidth{sel[k]}});
    end
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (!stall_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // spread of the selected window
  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      spread_q <= hi - lo;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign spread_o = spread_q;

endmodule

// ===== rtl/core/wpp_best.sv =====
// largest spread tracker and result register
// keeps the best spread of the set, hands it out on the last item; uses wpp_pkg

module wpp_best #(
  parameter int unsigned SampleWidth = wpp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wpp_pkg::wpp_ctrl_t        ctrl_i,
  input  logic [SampleWidth-1:0]    spread_i,
  input  logic                      out_ready_i,
  output logic                      stall_o,
  output logic                      out_valid_o,
  output logic [wpp_pkg::OUT_W-1:0] best_spread_o
);
  import wpp_pkg::*;

  logic [SampleWidth-1:0] best_d, best_q;
  logic [SampleWidth-1:0] cand;
  logic [OUT_W-1:0]       cand_sat;
  logic [OUT_W-1:0]       out_data_q;
  logic                   out_valid_d, out_valid_q;
  logic                   stall;
  logic                   adv;

  // a closing item waits while the result register is still held
  assign stall = ctrl_i.valid && ctrl_i.last && out_valid_q && !out_ready_i;
  assign adv   = ctrl_i.valid && !stall;

  // running maximum of the spread
  always_comb begin
    cand = best_q;
    if (ctrl_i.full && (spread_i > best_q)) begin
      cand = spread_i;
    end
  end

  // clamp to the result width
  if (SampleWidth > OUT_W) begin : g_sat
    assign cand_sat = (cand[SampleWidth-1:OUT_W] != '0) ? '1 : cand[OUT_W-1:0];
  end else begin : g_ext
    assign cand_sat = OUT_W'(cand);
  end

  // next best and result valid
  always_comb begin
    best_d      = best_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      if (ctrl_i.last) begin
        best_d      = '0;
        out_valid_d = 1'b1;
      end else begin
        best_d = cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv && ctrl_i.last) begin
      out_data_q <= cand_sat;
    end
  end

  assign stall_o       = stall;
  assign out_valid_o   = out_valid_q;
  assign best_spread_o = out_data_q;

endmodule

// ===== rtl/core/window_peak_to_peak_max.sv =====
// top level of the window peak-to-peak maximum block
// builds the cell chain, fill counter and window length register;
// uses wpp_pkg, wpp_cell, wpp_select, wpp_best
//
// Usage:
//   Samples enter on in_valid_i/in_ready_o with sample_i and last_i; last_i
//   marks the final sample of a data set. For every full window of
//   window_length samples the spread (max - min) is taken and the largest
//   one of the set is kept. On the last sample one item leaves on
//   out_valid_o/out_ready_i carrying best_spread_o; other samples give none.
//   window_length_i is written on cfg_valid_i, always ready; the user must
//   write it only while idle, the block does not enforce this. A result is
//   valid once its last sample passes s1_q, the select stage and the result
//   register. Throughput: one sample per cycle while in_ready_o is high; each
//   cell of the chain updates in the cycle the sample is taken, the tap mux and
//   subtract take one stage, the best compare one more. A stalled receiver holds
//   the result register; samples keep flowing until a second last sample reaches
//   the compare stage, then in_ready_o drops until the held result is taken.
//   Reset empties the pipe, clears the fill count and best spread and sets
//   the window length to 1.

module window_peak_to_peak_max #(
  parameter int unsigned MAX_WINDOW   = wpp_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_WIDTH = wpp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [wpp_pkg::LEN_W-1:0] window_length_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]   sample_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [wpp_pkg::OUT_W-1:0] best_spread_o
);
  import wpp_pkg::*;

  localparam int unsigned FillW = $clog2(MAX_WINDOW + 1);

  logic [LEN_W-1:0]        len_q;
  logic [LEN_W-1:0]        eff_len;
  logic [FillW-1:0]        fill_d, fill_q, fill_inc;
  logic                    accept;
  logic                    stall;
  logic                    full;
  wpp_ctrl_t               s1_d, s1_q;
  wpp_ctrl_t               s2;
  logic [SAMPLE_WIDTH-1:0] spread;
  logic [SAMPLE_WIDTH-1:0] cell_max [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] cell_min [MAX_WINDOW];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !stall;
  assign accept      = in_valid_i && !stall;

  // window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      len_q <= window_length_i;
    end
  end

  // lengths above the chain depth use the whole chain
  assign eff_len = (32'(len_q) > 32'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : len_q;

  // fill count saturating at the chain depth, cleared after a last item
  always_comb begin
    fill_inc = (fill_q < FillW'(MAX_WINDOW)) ? fill_q + FillW'(1) : fill_q;
    full     = (eff_len != '0) && (32'(fill_inc) >= 32'(eff_len));
    fill_d   = fill_q;
    if (accept) begin
      fill_d = last_i ? '0 : fill_inc;
    end
    s1_d       = s1_q;
    if (!stall) begin
      s1_d.valid = accept;
      s1_d.last  = last_i;
      s1_d.full  = full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      s1_q   <= '0;
    end else begin
      fill_q <= fill_d;
      s1_q   <= s1_d;
    end
  end

  // chain of cells, cell 0 folds the sample with itself
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      wpp_cell #(
        .SampleWidth(SAMPLE_WIDTH)
      ) u_cell (
        .clk_i     (clk_i),
        .en_i      (accept),
        .sample_i  (sample_i),
        .prev_max_i(sample_i),
        .prev_min_i(sample_i),
        .max_o     (cell_max[k]),
        .min_o     (cell_min[k])
      );
    end else begin : g_body
      wpp_cell #(
        .SampleWidth(SAMPLE_WIDTH)
      ) u_cell (
        .clk_i     (clk_i),
        .en_i      (accept),
        .sample_i  (sample_i),
        .prev_max_i(cell_max[k-1]),
        .prev_min_i(cell_min[k-1]),
        .max_o     (cell_max[k]),
        .min_o     (cell_min[k])
      );
    end
  end

  // tap select and spread
  wpp_select #(
    .MaxWindow  (MAX_WINDOW),
    .SampleWidth(SAMPLE_WIDTH)
  ) u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stall_i (stall),
    .len_i   (eff_len),
    .ctrl_i  (s1_q),
    .max_i   (cell_max),
    .min_i   (cell_min),
    .ctrl_o  (s2),
    .spread_o(spread)
  );

  // best spread and result register
  wpp_best #(
    .SampleWidth(SAMPLE_WIDTH)
  ) u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (s2),
    .spread_i     (spread),
    .out_ready_i  (out_ready_i),
    .stall_o      (stall),
    .out_valid_o  (out_valid_o),
    .best_spread_o(best_spread_o)
  );

  // backpressure only comes from a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled without a held result");

  // fill count never passes the chain depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(MAX_WINDOW))
    else $error("fill count beyond chain depth");

  // a last item starts a fresh set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> (fill_q == '0))
    else $error("fill count not cleared after last item");

  // a held result never takes a new closing item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && s2.valid && s2.last) |=> $stable(best_spread_o))
    else $error("held result overwritten");

endmodule

// ===== test/tb_window_peak_to_peak_max.sv =====
// testbench for window_peak_to_peak_max: directed and random data sets,
// a scoreboard that recomputes the best window spread of each set
// depends on wpp_pkg and the window_peak_to_peak_max rtl

module tb_window_peak_to_peak_max;

  localparam int unsigned WIN_MAX      = wpp_pkg::MAX_WINDOW_DEF;
  localparam int unsigned SW           = wpp_pkg::SAMPLE_WIDTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 1000;

  typedef logic [SW-1:0]             sample_t;
  typedef logic [wpp_pkg::OUT_W-1:0] spread_t;
  typedef logic [wpp_pkg::LEN_W-1:0] wlen_t;

  typedef enum {RX_ALWAYS, RX_COIN, RX_RUNS} rx_mode_e;

  // scoreboard: running spread of the open set and expected results
  class spread_board;
    sample_t     held[$];
    spread_t     best = '0;
    wlen_t       win_len = 1;
    spread_t     expected[$];
    int unsigned errors;

    function void set_window(wlen_t v);
      win_len = v;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function void note_sample(sample_t s, bit l);
      int      span;
      int      k;
      sample_t hi;
      sample_t lo;
      held.push_back(s);
      if (held.size() > WIN_MAX) void'(held.pop_front());
      span = (win_len > WIN_MAX) ? WIN_MAX : win_len;
      // spread of the newest full window
      if (span != 0 && held.size() >= span) begin
        hi = '0;
        lo = '1;
        for (k = held.size() - span; k < held.size(); k++) begin
          if (held[k] > hi) hi = held[k];
          if (held[k] < lo) lo = held[k];
        end
        if (spread_t'(hi - lo) > best) best = hi - lo;
      end
      // last sample closes the set
      if (l) begin
        expected.push_back(best);
        best = '0;
        held.delete();
      end
    endfunction

    function void check_spread(spread_t got);
      spread_t want;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: best_spread expected none actual %h", $time, got);
        return;
      end
      want = expected.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: best_spread expected %h actual %h", $time, want, got);
      end
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_valid_i;
  logic    cfg_ready_o;
  wlen_t   window_length_i;
  logic    in_valid_i;
  logic    in_ready_o;
  sample_t sample_i;
  logic    last_i;
  logic    out_valid_o;
  logic    out_ready_i;
  spread_t best_spread_o;

  spread_board board = new();

  int unsigned burst_left;
  int unsigned items_sent;
  sample_t     cluster_base;
  rx_mode_e    rx_mode;
  int unsigned rx_left = 0;
  int unsigned run_left = 0;
  logic        run_level = 1'b0;

  window_peak_to_peak_max dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .window_length_i (window_length_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .best_spread_o   (best_spread_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: check each taken result, stall on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_spread(best_spread_o);
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_ALWAYS: begin
        out_ready_i <= 1'b1;
      end
      RX_COIN: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (run_left == 0) begin
          run_level = ~run_level;
          run_left  = $urandom_range(1, 30);
        end
        run_left--;
        out_ready_i <= run_level;
      end
    endcase
  end

  // one item, held until taken
  task automatic push_sample(sample_t s, bit l);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(s, l);
    items_sent++;
  endtask

  // item sent in bursts with random gaps in between
  task automatic send_paced(sample_t s, bit l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push_sample(s, l);
  endtask

  task automatic write_window(wlen_t v);
    cfg_valid_i     <= 1'b1;
    window_length_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_window(v);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending, let every result out and the pipe drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom();
    else if (r < 7) return cluster_base + $urandom_range(0, 255);
    else if (r == 7) return '0;
    else if (r == 8) return '1;
    else return sample_t'(1) << $urandom_range(0, SW - 1);
  endfunction

  task automatic run_directed();
    // default length of one: single-sample set
    push_sample(32'h1234_5678, 1'b1);
    // length two: full-scale spread, then a set shorter than the window
    wait_idle();
    write_window(2);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    push_sample(32'h0000_0005, 1'b1);
    // zero length never fills a window
    wait_idle();
    write_window(0);
    push_sample(32'h0000_0007, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h0000_0000, 1'b1);
    // lengths above the store size clamp to it: short set
    wait_idle();
    write_window(127);
    push_sample(32'hAAAA_AAAA, 1'b0);
    push_sample(32'h5555_5555, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    wait_idle();
    write_window(65);
    push_sample(32'h0000_0001, 1'b0);
    push_sample(32'h8000_0000, 1'b1);
    // length changed while a set is open
    wait_idle();
    write_window(3);
    push_sample(32'd10, 1'b0);
    push_sample(32'd50, 1'b0);
    wait_idle();
    write_window(2);
    push_sample(32'd20, 1'b1);
  endtask

  task automatic run_random();
    int unsigned target;
    int unsigned phase;
    int unsigned span;
    int unsigned sets;
    int unsigned set_len;
    int unsigned i;
    int unsigned j;
    bit          open_set;
    wlen_t       v;
    wlen_t       edge_lens[6];
    edge_lens = '{1, 64, 0, 65, 127, 2};
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      // every phase starts idle with a new window length
      wait_idle();
      if (phase < 6) v = edge_lens[phase];
      else if ($urandom_range(0, 9) < 7) v = wlen_t'($urandom_range(1, 12));
      else v = wlen_t'($urandom_range(0, 127));
      write_window(v);
      phase++;
      span = (v == 0) ? 8 : ((v > WIN_MAX) ? WIN_MAX : v);
      sets = $urandom_range(2, 8);
      for (i = 0; i < sets; i++) begin
        cluster_base = $urandom();
        if ($urandom_range(0, 7) == 0) set_len = $urandom_range(1, WIN_MAX + 8);
        else set_len = $urandom_range(1, 2 * span + 3);
        // now and then the final set stays open across the next length change
        open_set = (i == sets - 1) && ($urandom_range(0, 3) == 0);
        for (j = 0; j < set_len; j++) begin
          send_paced(pick_sample(), (j == set_len - 1) && !open_set);
        end
      end
    end
    // close a set left open
    send_paced(pick_sample(), 1'b1);
  endtask

  // main sequence
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    window_length_i = '0;
    in_valid_i      = 1'b0;
    sample_i        = '0;
    last_i          = 1'b0;
    burst_left      = 0;
    items_sent      = 0;
    cluster_base    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    wait_idle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_window_peak_to_peak_max: done, clean");
    end else begin
      $display("tb_window_peak_to_peak_max: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb_window_peak_to_peak_max: done, errors");
    $finish;
  end

endmodule
